/* design/mftt_pkg.sv */
package mftt_pkg;

   // bank and encoder geometry
   localparam int MOTORS          = 4;
   localparam int IDX_W           = 2;
   localparam int ID_W            = 11;
   localparam int ANGLE_W         = 13;
   localparam int TURN_W          = 16;
   localparam int POS_W           = TURN_W + ANGLE_W;
   localparam int DEG_W           = 9;
   localparam int WORD_W          = 16;
   localparam int TEMP_W          = 8;
   localparam int COUNTS_PER_TURN = 1 << ANGLE_W;
   localparam int ANGLE_MAX       = COUNTS_PER_TURN - 1;
   localparam int DEGREES_PER_TURN = 360;

   // warm-up frame counter
   localparam int WARMUP_FRAMES = 5;
   localparam int FRAMES_W      = 3;

   // control registers
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 1;
   localparam logic [ID_W-1:0]    BASE_ID_RESET   = ID_W'(512);
   localparam logic [ANGLE_W-1:0] THRESHOLD_RESET = ANGLE_W'(4000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_ID        = 1'b0,
      CSR_WRAP_THRESHOLD = 1'b1
   } csr_index_type;

   // lookup result for the frame in the compute stage
   typedef struct packed {
      logic              hit;
      logic [IDX_W-1:0]  motor;
      logic [TURN_W-1:0] turns;
   } track_type;

endpackage

/* design/mftt_degrees.sv */
module mftt_degrees (
   input  logic [mftt_pkg::ANGLE_W-1:0] angle,
   output logic [mftt_pkg::DEG_W-1:0]   degrees
);

   localparam int PROD_W = mftt_pkg::ANGLE_W + mftt_pkg::DEG_W;

   logic [PROD_W-1:0]                product;
   logic [mftt_pkg::DEG_W-1:0]       quot_est;
   logic [mftt_pkg::ANGLE_W:0]       remainder;

   // scale to degrees, then divide by 2^n - 1: x = q*2^n + lo = q*(2^n-1) + (lo+q)
   always_comb begin
      product   = PROD_W'(angle) * PROD_W'(mftt_pkg::DEGREES_PER_TURN);
      quot_est  = product[PROD_W-1:mftt_pkg::ANGLE_W];
      remainder = (mftt_pkg::ANGLE_W+1)'(product[mftt_pkg::ANGLE_W-1:0])
                + (mftt_pkg::ANGLE_W+1)'(quot_est);
      // remainder stays below twice the divisor, so one correction suffices
      if (remainder >= (mftt_pkg::ANGLE_W+1)'(mftt_pkg::ANGLE_MAX)) begin
         degrees = quot_est + mftt_pkg::DEG_W'(1);
      end else begin
         degrees = quot_est;
      end
   end

endmodule

/* design/mftt_tracker.sv */
module mftt_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          commit,
   input  logic [mftt_pkg::ID_W-1:0]     frame_id,
   input  logic [mftt_pkg::ANGLE_W-1:0]  angle,
   input  logic [mftt_pkg::ID_W-1:0]     base_id,
   input  logic [mftt_pkg::ANGLE_W-1:0]  threshold,
   output mftt_pkg::track_type           track
);

   logic [mftt_pkg::TURN_W-1:0]   turn_ff      [mftt_pkg::MOTORS];
   logic [mftt_pkg::TURN_W-1:0]   turn_in      [mftt_pkg::MOTORS];
   logic [mftt_pkg::ANGLE_W-1:0]  prev_ff      [mftt_pkg::MOTORS];
   logic [mftt_pkg::ANGLE_W-1:0]  prev_in      [mftt_pkg::MOTORS];
   logic [mftt_pkg::FRAMES_W-1:0] frames_ff;
   logic [mftt_pkg::FRAMES_W-1:0] frames_in;

   logic [mftt_pkg::ID_W:0]       offset;
   logic                          hit;
   logic [mftt_pkg::IDX_W-1:0]    motor;
   logic                          warm;
   logic [mftt_pkg::ANGLE_W-1:0]  prev_sel;
   logic [mftt_pkg::TURN_W-1:0]   turn_sel;
   logic [mftt_pkg::ANGLE_W:0]    angle_plus_th;
   logic [mftt_pkg::ANGLE_W:0]    prev_plus_th;
   logic [mftt_pkg::TURN_W-1:0]   turn_next;

   // motor lookup: identifier minus base minus one, signed
   always_comb begin
      offset = {1'b0, frame_id} - {1'b0, base_id} - (mftt_pkg::ID_W+1)'(1);
      hit    = !offset[mftt_pkg::ID_W] &&
               (offset[mftt_pkg::ID_W-1:0] < mftt_pkg::ID_W'(mftt_pkg::MOTORS));
      motor  = offset[mftt_pkg::IDX_W-1:0];
   end

   // unwrap: a backward jump past the threshold is a turn up, forward is a turn down
   always_comb begin
      warm          = frames_ff >= mftt_pkg::FRAMES_W'(mftt_pkg::WARMUP_FRAMES);
      prev_sel      = prev_ff[motor];
      turn_sel      = turn_ff[motor];
      angle_plus_th = {1'b0, angle} + {1'b0, threshold};
      prev_plus_th  = {1'b0, prev_sel} + {1'b0, threshold};
      turn_next     = turn_sel;
      if (warm) begin
         if (angle_plus_th < {1'b0, prev_sel}) begin
            turn_next = turn_sel + mftt_pkg::TURN_W'(1);
         end else if ({1'b0, angle} > prev_plus_th) begin
            turn_next = turn_sel - mftt_pkg::TURN_W'(1);
         end
      end
      track.hit   = hit;
      track.motor = motor;
      track.turns = turn_next;
   end

   // next state for the bank and the warm-up counter
   always_comb begin
      for (int k = 0; k < mftt_pkg::MOTORS; k++) begin
         turn_in[k] = turn_ff[k];
         prev_in[k] = prev_ff[k];
      end
      frames_in = frames_ff;
      if (commit) begin
         if (!warm) begin
            frames_in = frames_ff + mftt_pkg::FRAMES_W'(1);
         end
         if (hit) begin
            turn_in[motor] = turn_next;
            prev_in[motor] = angle;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= '0;
         for (int k = 0; k < mftt_pkg::MOTORS; k++) begin
            turn_ff[k] <= '0;
            prev_ff[k] <= '0;
         end
      end else begin
         frames_ff <= frames_in;
         for (int k = 0; k < mftt_pkg::MOTORS; k++) begin
            turn_ff[k] <= turn_in[k];
            prev_ff[k] <= prev_in[k];
         end
      end
   end

endmodule

/* design/motor_feedback_turn_tracker.sv */
// Multi-turn angle tracker for a bank of motors fed by feedback frames.
// Input channel req_*: one feedback frame per transfer (identifier, 13-bit
// encoder angle, speed, current, temperature). Output channel rsp_*: exactly
// one result per frame, in order: valid flag, motor index, multi-turn
// position, angle in degrees, and the pass-through words. Frames whose
// identifier does not map to a motor give an all-zero result with the valid
// flag low and leave the per-motor state alone.
// The result passes through the input register, then the turn update and
// degree scaling land in the output register. Throughput is one frame per
// cycle while rsp_ready stays high, set by the single compute stage, which
// updates the per-motor turn state in the same cycle that the next frame
// moves into the input register.
// When rsp_ready is low the result holds, the input register still takes one
// more frame, and req_ready then drops until the result moves on.
// Reset (synchronous) empties both stages, clears all turn counts, previous
// angles and the warm-up counter, and loads base_id 512 and threshold 4000.
// csr_we writes base_id (index 0) or wrap_threshold (index 1) at once;
// write only while no frame is in flight.
module motor_feedback_turn_tracker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mftt_pkg::ID_W-1:0]         req_frame_id,
   input  logic [mftt_pkg::ANGLE_W-1:0]      req_encoder_angle,
   input  logic signed [mftt_pkg::WORD_W-1:0] req_speed_word,
   input  logic signed [mftt_pkg::WORD_W-1:0] req_current_word,
   input  logic [mftt_pkg::TEMP_W-1:0]       req_temperature,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_valid_res,
   output logic [mftt_pkg::IDX_W-1:0]        rsp_motor_index,
   output logic signed [mftt_pkg::POS_W-1:0] rsp_position,
   output logic [mftt_pkg::DEG_W-1:0]        rsp_angle_degrees,
   output logic signed [mftt_pkg::WORD_W-1:0] rsp_velocity,
   output logic signed [mftt_pkg::WORD_W-1:0] rsp_current,
   output logic [mftt_pkg::TEMP_W-1:0]       rsp_temperature_out,
   input  logic                              csr_we,
   input  logic [mftt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mftt_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [mftt_pkg::ID_W-1:0]    base_id_ff;
   logic [mftt_pkg::ANGLE_W-1:0] threshold_ff;

   logic                                in_valid_ff;
   logic [mftt_pkg::ID_W-1:0]           in_id_ff;
   logic [mftt_pkg::ANGLE_W-1:0]        in_angle_ff;
   logic [mftt_pkg::WORD_W-1:0]         in_speed_ff;
   logic [mftt_pkg::WORD_W-1:0]         in_current_ff;
   logic [mftt_pkg::TEMP_W-1:0]         in_temp_ff;

   logic                                out_valid_ff;
   logic                                out_valid_in;
   logic                                out_hit_ff;
   logic [mftt_pkg::IDX_W-1:0]          out_motor_ff;
   logic [mftt_pkg::POS_W-1:0]          out_pos_ff;
   logic [mftt_pkg::DEG_W-1:0]          out_deg_ff;
   logic [mftt_pkg::WORD_W-1:0]         out_speed_ff;
   logic [mftt_pkg::WORD_W-1:0]         out_current_ff;
   logic [mftt_pkg::TEMP_W-1:0]         out_temp_ff;

   logic                                advance;
   logic                                commit;
   logic                                in_valid_in;
   mftt_pkg::track_type                 track;
   logic [mftt_pkg::DEG_W-1:0]          degrees;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_id_ff   <= mftt_pkg::BASE_ID_RESET;
         threshold_ff <= mftt_pkg::THRESHOLD_RESET;
      end else if (csr_we) begin
         case (mftt_pkg::csr_index_type'(csr_index))
            mftt_pkg::CSR_BASE_ID:        base_id_ff   <= csr_wdata[mftt_pkg::ID_W-1:0];
            mftt_pkg::CSR_WRAP_THRESHOLD: threshold_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage handshake: compute stage moves when the output register frees up
   always_comb begin
      advance      = !out_valid_ff || rsp_ready;
      commit       = in_valid_ff && advance;
      req_ready    = !in_valid_ff || advance;
      in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_id_ff      <= req_frame_id;
         in_angle_ff   <= req_encoder_angle;
         in_speed_ff   <= req_speed_word;
         in_current_ff <= req_current_word;
         in_temp_ff    <= req_temperature;
      end
   end

   mftt_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .commit    (commit),
      .frame_id  (in_id_ff),
      .angle     (in_angle_ff),
      .base_id   (base_id_ff),
      .threshold (threshold_ff),
      .track     (track)
   );

   mftt_degrees u_degrees (
      .angle   (in_angle_ff),
      .degrees (degrees)
   );

   // output register; frames that miss the bank give an all-zero result
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         out_hit_ff <= track.hit;
         if (track.hit) begin
            out_motor_ff   <= track.motor;
            out_pos_ff     <= {track.turns, in_angle_ff};
            out_deg_ff     <= degrees;
            out_speed_ff   <= in_speed_ff;
            out_current_ff <= in_current_ff;
            out_temp_ff    <= in_temp_ff;
         end else begin
            out_motor_ff   <= '0;
            out_pos_ff     <= '0;
            out_deg_ff     <= '0;
            out_speed_ff   <= '0;
            out_current_ff <= '0;
            out_temp_ff    <= '0;
         end
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_valid_res       = out_hit_ff;
   assign rsp_motor_index     = out_motor_ff;
   assign rsp_position        = out_pos_ff;
   assign rsp_angle_degrees   = out_deg_ff;
   assign rsp_velocity        = out_speed_ff;
   assign rsp_current         = out_current_ff;
   assign rsp_temperature_out = out_temp_ff;

   // a frame in the compute stage reaches the output register once it moves
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      commit |=> out_valid_ff)
      else $error("committed frame did not reach the output register");

   // a stalled compute stage keeps its frame
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_id_ff) && $stable(in_angle_ff))
      else $error("compute stage lost its frame while stalled");

   // an empty compute stage always takes a frame
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input not ready with an empty compute stage");

   // a miss gives a zero result
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_hit_ff |-> out_pos_ff == '0 && out_temp_ff == '0)
      else $error("result of an unmapped frame is not zero");

   // degrees never exceed a full turn
   a_deg_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_deg_ff <= mftt_pkg::DEG_W'(mftt_pkg::DEGREES_PER_TURN))
      else $error("angle in degrees out of range");

endmodule

/* bench/motor_feedback_turn_tracker_test.sv */
module motor_feedback_turn_tracker_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD  = 20;
   localparam int RESET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int REPORT_LIMIT  = 200;
   localparam int SCRIPT_ROWS   = 20;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 280;
   localparam int SPIN_TURNS    = 40;
   localparam int HOLD_CYCLES   = 80;

   typedef struct packed {
      logic [mftt_pkg::ID_W-1:0]          frame_id;
      logic [mftt_pkg::ANGLE_W-1:0]       angle;
      logic signed [mftt_pkg::WORD_W-1:0] speed;
      logic signed [mftt_pkg::WORD_W-1:0] current;
      logic [mftt_pkg::TEMP_W-1:0]        temperature;
   } feedback_frame_type;

   typedef struct packed {
      logic                               hit;
      logic [mftt_pkg::IDX_W-1:0]         motor;
      logic signed [mftt_pkg::POS_W-1:0]  position;
      logic [mftt_pkg::DEG_W-1:0]         degrees;
      logic signed [mftt_pkg::WORD_W-1:0] velocity;
      logic signed [mftt_pkg::WORD_W-1:0] current;
      logic [mftt_pkg::TEMP_W-1:0]        temperature;
   } tracker_result_type;

   // one scripted frame; when known is set the result fields are typed in here
   typedef struct packed {
      feedback_frame_type                frame;
      logic                              known;
      logic                              hit;
      logic [mftt_pkg::IDX_W-1:0]        motor;
      logic signed [mftt_pkg::POS_W-1:0] position;
      logic [mftt_pkg::DEG_W-1:0]        degrees;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [mftt_pkg::ID_W-1:0]          req_frame_id = '0;
   logic [mftt_pkg::ANGLE_W-1:0]       req_encoder_angle = '0;
   logic signed [mftt_pkg::WORD_W-1:0] req_speed_word = '0;
   logic signed [mftt_pkg::WORD_W-1:0] req_current_word = '0;
   logic [mftt_pkg::TEMP_W-1:0]        req_temperature = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic                               rsp_valid_res;
   logic [mftt_pkg::IDX_W-1:0]         rsp_motor_index;
   logic signed [mftt_pkg::POS_W-1:0]  rsp_position;
   logic [mftt_pkg::DEG_W-1:0]         rsp_angle_degrees;
   logic signed [mftt_pkg::WORD_W-1:0] rsp_velocity;
   logic signed [mftt_pkg::WORD_W-1:0] rsp_current;
   logic [mftt_pkg::TEMP_W-1:0]        rsp_temperature_out;
   logic                               csr_we = 1'b0;
   logic [mftt_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [mftt_pkg::CSR_DATA_W-1:0]    csr_wdata = '0;

   // shadow of the tracker state and its registers
   logic [mftt_pkg::ID_W-1:0]    bank_base_id = mftt_pkg::BASE_ID_RESET;
   logic [mftt_pkg::ANGLE_W-1:0] bank_threshold = mftt_pkg::THRESHOLD_RESET;
   logic [mftt_pkg::TURN_W-1:0]  bank_turns [mftt_pkg::MOTORS];
   logic [mftt_pkg::ANGLE_W-1:0] bank_last_angle [mftt_pkg::MOTORS];
   int                           warmup_seen = 0;

   tracker_result_type predicted_feedback [$];

   int idle_pct = 0;
   int stall_pct = 0;
   bit hold_request = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   script_row_type script [SCRIPT_ROWS] = '{
      // warm-up: a full jump on motor 1 counts no turn
      '{'{11'd513, 13'd0, 16'h0000, 16'h0000, 8'd0}, 1'b1, 1'b1, 2'd0, 29'sd0, 9'd0},
      '{'{11'd514, 13'd8191, 16'h8000, 16'h7FFF, 8'd255}, 1'b1, 1'b1, 2'd1, 29'sd8191, 9'd360},
      // identifiers outside the bank
      '{'{11'd0, 13'd8191, 16'hFFFF, 16'hFFFF, 8'd255}, 1'b1, 1'b0, 2'd0, 29'sd0, 9'd0},
      '{'{11'd2047, 13'd8191, 16'h7FFF, 16'h8000, 8'd255}, 1'b1, 1'b0, 2'd0, 29'sd0, 9'd0},
      '{'{11'd512, 13'd100, 16'h0005, 16'h0005, 8'd5}, 1'b1, 1'b0, 2'd0, 29'sd0, 9'd0},
      '{'{11'd517, 13'd100, 16'h1234, 16'h4321, 8'd7}, 1'b1, 1'b0, 2'd0, 29'sd0, 9'd0},
      // warm: wrap back counts up, wrap forward counts down
      '{'{11'd514, 13'd0, 16'h0100, 16'hFF00, 8'd30}, 1'b1, 1'b1, 2'd1, 29'sd8192, 9'd0},
      '{'{11'd514, 13'd8191, 16'h0200, 16'hFE00, 8'd31}, 1'b1, 1'b1, 2'd1, 29'sd8191, 9'd360},
      '{'{11'd513, 13'd8191, 16'h0001, 16'hFFFF, 8'd40}, 1'b1, 1'b1, 2'd0, -29'sd1, 9'd360},
      '{'{11'd513, 13'd0, 16'h0002, 16'hFFFE, 8'd41}, 1'b1, 1'b1, 2'd0, 29'sd0, 9'd0},
      // jumps right at and just past the threshold
      '{'{11'd513, 13'd4000, 16'h0003, 16'h0003, 8'd42}, 1'b0, 1'b0, 2'd0, 29'sd0, 9'd0},
      '{'{11'd513, 13'd0, 16'h0004, 16'h0004, 8'd43}, 1'b1, 1'b1, 2'd0, 29'sd0, 9'd0},
      '{'{11'd513, 13'd4001, 16'h0005, 16'h0005, 8'd44}, 1'b0, 1'b0, 2'd0, 29'sd0, 9'd0},
      '{'{11'd513, 13'd0, 16'h0006, 16'h0006, 8'd45}, 1'b1, 1'b1, 2'd0, 29'sd0, 9'd0},
      '{'{11'd515, 13'd4095, 16'h7000, 16'h9000, 8'd60}, 1'b0, 1'b0, 2'd0, 29'sd0, 9'd0},
      '{'{11'd516, 13'd1, 16'h0001, 16'h0001, 8'd1}, 1'b0, 1'b0, 2'd0, 29'sd0, 9'd0},
      '{'{11'd516, 13'd8191, 16'hAAAA, 16'h5555, 8'hA5}, 1'b1, 1'b1, 2'd3, -29'sd1, 9'd360},
      '{'{11'd516, 13'd8191, 16'h5555, 16'hAAAA, 8'h5A}, 1'b0, 1'b0, 2'd0, 29'sd0, 9'd0},
      '{'{11'd516, 13'd0, 16'h0F0F, 16'hF0F0, 8'h0F}, 1'b1, 1'b1, 2'd3, 29'sd0, 9'd0},
      '{'{11'd1024, 13'h1555, 16'h5555, 16'hAAAA, 8'h5A}, 1'b1, 1'b0, 2'd0, 29'sd0, 9'd0}
   };

   motor_feedback_turn_tracker dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_frame_id        (req_frame_id),
      .req_encoder_angle   (req_encoder_angle),
      .req_speed_word      (req_speed_word),
      .req_current_word    (req_current_word),
      .req_temperature     (req_temperature),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_valid_res       (rsp_valid_res),
      .rsp_motor_index     (rsp_motor_index),
      .rsp_position        (rsp_position),
      .rsp_angle_degrees   (rsp_angle_degrees),
      .rsp_velocity        (rsp_velocity),
      .rsp_current         (rsp_current),
      .rsp_temperature_out (rsp_temperature_out),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   initial begin
      for (int m = 0; m < mftt_pkg::MOTORS; m++) begin
         bank_turns[m] = '0;
         bank_last_angle[m] = '0;
      end
   end

   // track one frame: turn update on the shadow state, then the result it gives
   function automatic tracker_result_type track_frame(input feedback_frame_type f);
      tracker_result_type r;
      int slot;
      int jump;
      bit warm;
      r = '0;
      slot = int'(f.frame_id) - int'(bank_base_id) - 1;
      warm = (warmup_seen >= mftt_pkg::WARMUP_FRAMES);
      if (!warm)
         warmup_seen++;
      if (slot >= 0 && slot < mftt_pkg::MOTORS) begin
         if (warm) begin
            jump = int'(f.angle) - int'(bank_last_angle[slot]);
            if (jump < -int'(bank_threshold))
               bank_turns[slot] = bank_turns[slot] + 1'b1;
            if (jump > int'(bank_threshold))
               bank_turns[slot] = bank_turns[slot] - 1'b1;
         end
         bank_last_angle[slot] = f.angle;
         r.hit = 1'b1;
         r.motor = mftt_pkg::IDX_W'(slot);
         r.position = mftt_pkg::POS_W'($signed(bank_turns[slot]) * mftt_pkg::COUNTS_PER_TURN
                                       + int'(f.angle));
         r.degrees = mftt_pkg::DEG_W'((int'(f.angle) * mftt_pkg::DEGREES_PER_TURN)
                                      / mftt_pkg::ANGLE_MAX);
         r.velocity = f.speed;
         r.current = f.current;
         r.temperature = f.temperature;
      end
      return r;
   endfunction

   // mostly plausible motion on a bank motor, the rest stray frames
   function automatic feedback_frame_type make_frame();
      feedback_frame_type f;
      int slot;
      int step;
      f.speed = mftt_pkg::WORD_W'($urandom);
      f.current = mftt_pkg::WORD_W'($urandom);
      f.temperature = mftt_pkg::TEMP_W'($urandom);
      slot = $urandom_range(0, mftt_pkg::MOTORS - 1);
      if ($urandom_range(0, 99) < 82) begin
         f.frame_id = mftt_pkg::ID_W'(int'(bank_base_id) + 1 + slot);
         case ($urandom_range(0, 3))
            0: step = int'(bank_threshold) + int'($urandom_range(0, 1));
            1: step = -int'(bank_threshold) - int'($urandom_range(0, 1));
            default: begin
               step = $urandom_range(0, 1200);
               step = step - 600;
            end
         endcase
         f.angle = mftt_pkg::ANGLE_W'(int'(bank_last_angle[slot]) + step);
      end else begin
         if ($urandom_range(0, 1) == 0)
            f.frame_id = mftt_pkg::ID_W'($urandom_range(0, 2047));
         else if ($urandom_range(0, 1) == 0)
            f.frame_id = bank_base_id;
         else
            f.frame_id = mftt_pkg::ID_W'(int'(bank_base_id) + mftt_pkg::MOTORS + 1);
         f.angle = mftt_pkg::ANGLE_W'($urandom);
      end
      return f;
   endfunction

   // offer one frame, with random idle cycles first, and wait for its transfer
   task automatic send_frame(input feedback_frame_type f);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_frame_id <= f.frame_id;
      req_encoder_angle <= f.angle;
      req_speed_word <= f.speed;
      req_current_word <= f.current;
      req_temperature <= f.temperature;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // stop offering and wait until every frame in flight has come out
   task automatic settle_block();
      req_valid <= 1'b0;
      while (predicted_feedback.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input mftt_pkg::csr_index_type which,
                                 input int unsigned value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= which;
      csr_wdata <= mftt_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      if (which == mftt_pkg::CSR_BASE_ID)
         bank_base_id = mftt_pkg::ID_W'(value);
      else
         bank_threshold = mftt_pkg::ANGLE_W'(value);
   endtask

   function automatic void compare_field(input string field, input logic signed [31:0] want,
                                         input logic signed [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         // keep the log readable when the block is badly off
         if (mismatch_count <= REPORT_LIMIT)
            $error("%s: expected %0d, got %0d", field, want, got);
      end
   endfunction

   // receiver: one long hold-off on request, otherwise random stalls
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // result check against the oldest prediction
   always @(posedge clock) begin
      tracker_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_feedback.size() == 0) begin
            mismatch_count++;
            $error("result transfer with nothing expected, position %0d", rsp_position);
         end else begin
            want = predicted_feedback.pop_front();
            compare_field("valid_res", want.hit, rsp_valid_res);
            compare_field("motor_index", want.motor, rsp_motor_index);
            compare_field("position", want.position, rsp_position);
            compare_field("angle_degrees", want.degrees, rsp_angle_degrees);
            compare_field("velocity", want.velocity, rsp_velocity);
            compare_field("current", want.current, rsp_current);
            compare_field("temperature_out", want.temperature, rsp_temperature_out);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      tracker_result_type expected;
      feedback_frame_type frame;
      int unsigned base_pick;
      int unsigned threshold_pick;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // scripted frames on reset settings
      for (int n = 0; n < SCRIPT_ROWS; n++) begin
         send_frame(script[n].frame);
         expected = track_frame(script[n].frame);
         if (script[n].known) begin
            expected.hit = script[n].hit;
            expected.motor = script[n].motor;
            expected.position = script[n].position;
            expected.degrees = script[n].degrees;
            // pass-through words read zero on a stray identifier
            expected.velocity = script[n].hit ? script[n].frame.speed : '0;
            expected.current = script[n].hit ? script[n].frame.current : '0;
            expected.temperature = script[n].hit ? script[n].frame.temperature : '0;
         end
         predicted_feedback.push_back(expected);
      end
      settle_block();

      // spin motor 2 forward through a run of turns, one turn every three frames
      write_register(mftt_pkg::CSR_WRAP_THRESHOLD, 4096);
      for (int k = 0; k < 3 * SPIN_TURNS; k++) begin
         frame = make_frame();
         frame.frame_id = mftt_pkg::ID_W'(int'(bank_base_id) + 3);
         case (k % 3)
            0: frame.angle = '0;
            1: frame.angle = mftt_pkg::ANGLE_W'(mftt_pkg::COUNTS_PER_TURN / 2);
            default: frame.angle = mftt_pkg::ANGLE_W'(mftt_pkg::ANGLE_MAX);
         endcase
         send_frame(frame);
         predicted_feedback.push_back(track_frame(frame));
      end

      // random phases, each with its own register settings and idling mix
      for (int p = 0; p < PHASES; p++) begin
         settle_block();
         case (p)
            0: begin
               base_pick = 512;
               threshold_pick = 4000;
            end
            1: begin
               base_pick = 0;
               threshold_pick = 1;
            end
            2: begin
               base_pick = 2047;
               threshold_pick = mftt_pkg::ANGLE_MAX;
            end
            3: begin
               base_pick = 2043;
               threshold_pick = 0;
            end
            4: begin
               base_pick = $urandom_range(0, 2047);
               threshold_pick = $urandom_range(1, mftt_pkg::ANGLE_MAX);
            end
            default: begin
               base_pick = 1000;
               threshold_pick = 4096;
            end
         endcase
         write_register(mftt_pkg::CSR_BASE_ID, base_pick);
         write_register(mftt_pkg::CSR_WRAP_THRESHOLD, threshold_pick);
         case (p % 4)
            0: begin
               idle_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               idle_pct = 72;
               stall_pct <= 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct <= 72;
            end
            default: begin
               idle_pct = 14;
               stall_pct <= 14;
            end
         endcase
         // long receiver hold-off while frames keep coming
         if (p == 0)
            hold_request <= 1'b1;
         repeat (PHASE_ITEMS) begin
            frame = make_frame();
            send_frame(frame);
            predicted_feedback.push_back(track_frame(frame));
         end
      end
      settle_block();

      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
